@@ rtl/u8s_pkg.sv @@
// u8s_pkg: shared types and constants for the utf-8 stream sanitiser
// no dependencies; imported by u8s_decode and utf8_stream_sanitizer
`default_nettype none

package u8s_pkg;

    // widths of the transaction fields
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POINT_W  = 21;
    localparam int unsigned RAW_W    = 32;
    localparam int unsigned PEND_W   = 24;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned SEEN_W   = 2;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // lead byte ranges and payload masks
    localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF7;
    localparam logic [BYTE_W-1:0] MASK2     = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK3     = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK4     = 8'h07;
    localparam logic [1:0]        CONT_TAG  = 2'b10;

    // scalar value limits
    localparam logic [POINT_W-1:0] MIN2     = 21'h000080;
    localparam logic [POINT_W-1:0] MAX2     = 21'h0007FF;
    localparam logic [POINT_W-1:0] MIN3     = 21'h000800;
    localparam logic [POINT_W-1:0] SURR_LO  = 21'h00D7FF;
    localparam logic [POINT_W-1:0] SURR_HI  = 21'h00E000;
    localparam logic [POINT_W-1:0] MAX3     = 21'h00FFFF;
    localparam logic [POINT_W-1:0] MIN4     = 21'h010000;
    localparam logic [POINT_W-1:0] MAX4     = 21'h10FFFF;

    // input transaction
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic [RAW_W-1:0]   raw_sequence;
        logic [LEN_W-1:0]   sequence_length;
        logic               has_point;
        logic               end_of_text;
    } t_out_item;

    // pending sequence state
    typedef struct packed {
        logic [POINT_W-1:0] partial_point;
        logic [PEND_W-1:0]  partial_bytes;
        logic [LEN_W-1:0]   expected_length;
        logic [SEEN_W-1:0]  bytes_seen;
    } t_dec_state;

endpackage

`default_nettype wire

@@ rtl/u8s_decode.sv @@
// u8s_decode: pending sequence state and the per-byte decode step
// depends on u8s_pkg
`default_nettype none

module u8s_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire u8s_pkg::t_in_item  i_item,
    output logic                    o_emit,
    output u8s_pkg::t_out_item      o_result
);
    import u8s_pkg::*;

    t_dec_state               r_state;
    t_dec_state               n_state;
    logic [BYTE_W-1:0]        b;
    logic                     is_cont;
    logic                     pending;
    logic [LEN_W-1:0]         seen;
    logic [POINT_W-1:0]       pt;
    logic [4:0]               shamt;
    logic [RAW_W-1:0]         shifted;
    logic                     got;
    logic [POINT_W-1:0]       cp;
    logic [RAW_W-1:0]         raw;
    logic [LEN_W-1:0]         len;

    // shortest-form and range check of a finished sequence: no overlong, no surrogate, nothing past MAX4
    function automatic logic point_ok(input logic [LEN_W-1:0] n,
                                      input logic [POINT_W-1:0] v);
        logic ok;
        ok = 1'b0;
        case (n)
            LEN_TWO:   ok = (v >= MIN2) && (v <= MAX2);
            LEN_THREE: ok = ((v >= MIN3) && (v <= SURR_LO)) ||
                            ((v >= SURR_HI) && (v <= MAX3));
            LEN_FOUR:  ok = (v >= MIN4) && (v <= MAX4);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

    // decode one byte against the pending sequence
    always_comb begin
        b       = i_item.text_byte;
        is_cont = (b[7:6] == CONT_TAG);
        pending = (r_state.expected_length != LEN_NONE);
        seen    = {1'b0, r_state.bytes_seen} + LEN_ONE;
        pt      = {r_state.partial_point[POINT_W-7:0], b[5:0]};
        shamt   = {r_state.bytes_seen, 3'b000};
        shifted = {{(RAW_W-BYTE_W){1'b0}}, b} << shamt;
        n_state = '0;
        got     = 1'b0;
        cp      = '0;
        raw     = '0;
        len     = LEN_NONE;

        if (pending && is_cont) begin
            if (seen == r_state.expected_length) begin
                // sequence complete
                got = point_ok(r_state.expected_length, pt);
                cp  = pt;
                raw = {{(RAW_W-PEND_W){1'b0}}, r_state.partial_bytes} | shifted;
                len = r_state.expected_length;
            end else begin
                n_state.partial_point   = pt;
                n_state.partial_bytes   = r_state.partial_bytes | shifted[PEND_W-1:0];
                n_state.expected_length = r_state.expected_length;
                n_state.bytes_seen      = seen[SEEN_W-1:0];
            end
        end else begin
            // fresh byte, any broken sequence is dropped
            if (b != '0 && !b[7]) begin
                got = 1'b1;
                cp  = {{(POINT_W-BYTE_W){1'b0}}, b};
                raw = {{(RAW_W-BYTE_W){1'b0}}, b};
                len = LEN_ONE;
            end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
                n_state.expected_length = LEN_TWO;
                n_state.bytes_seen      = SEEN_W'(1);
                n_state.partial_point   = {{(POINT_W-BYTE_W){1'b0}}, b & MASK2};
                n_state.partial_bytes   = {{(PEND_W-BYTE_W){1'b0}}, b};
            end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
                n_state.expected_length = LEN_THREE;
                n_state.bytes_seen      = SEEN_W'(1);
                n_state.partial_point   = {{(POINT_W-BYTE_W){1'b0}}, b & MASK3};
                n_state.partial_bytes   = {{(PEND_W-BYTE_W){1'b0}}, b};
            end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
                n_state.expected_length = LEN_FOUR;
                n_state.bytes_seen      = SEEN_W'(1);
                n_state.partial_point   = {{(POINT_W-BYTE_W){1'b0}}, b & MASK4};
                n_state.partial_bytes   = {{(PEND_W-BYTE_W){1'b0}}, b};
            end
        end

        // last byte closes any pending sequence
        if (i_item.final_byte) begin
            n_state = '0;
        end

        o_emit                   = got || i_item.final_byte;
        o_result.code_point      = got ? cp : '0;
        o_result.raw_sequence    = got ? raw : '0;
        o_result.sequence_length = got ? len : LEN_NONE;
        o_result.has_point       = got;
        o_result.end_of_text     = i_item.final_byte;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_sanitizer.sv @@
// utf8_stream_sanitizer: top level, input register, decode step, result register
// depends on u8s_pkg and u8s_decode
`default_nettype none

// Sanitises a UTF-8 byte stream one byte per cycle while the result side
// does not stall. Each input transaction is one byte with a last-byte mark;
// ASCII other than NUL passes through, well-formed multi-byte sequences
// come out as code point plus raw bytes on their final byte, and broken,
// overlong, surrogate or out-of-range sequences vanish. The last byte
// always yields a result with end_of_text set. An accepted byte is held in
// the input register, and its result, if any, is written to the result
// register as the byte leaves it; the single pending-sequence state in the
// decode step is updated as each byte leaves the input register.
// Stall from the result side holds both registers.
module utf8_stream_sanitizer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire u8s_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output u8s_pkg::t_out_item      o_out_item
);
    import u8s_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_free;
    logic      advance;
    logic      in_take;
    logic      dec_emit;
    t_out_item dec_result;

    // handshake between the two registers
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // decode step
    u8s_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_emit   (dec_emit),
        .o_result (dec_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && dec_emit) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_emit) begin
            r_out_item <= dec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ bench/utf8_stream_sanitizer_tb.sv @@
// utf8_stream_sanitizer_tb: self-checking bench for the utf-8 stream sanitiser
// drives byte transactions, predicts each result and checks every field
// depends on u8s_pkg and utf8_stream_sanitizer
`default_nettype none

module utf8_stream_sanitizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8s_pkg::*;

    localparam int unsigned STALL_LIMIT = 500;
    localparam int unsigned TEXT_TARGET = 450;
    localparam int unsigned CALM_TAIL   = 60;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // bytes waiting to be offered, and results still owed by the block
    t_in_item  text_queue[$];
    t_out_item points_due[$];

    // predicted pending sequence
    logic [POINT_W-1:0] pend_point = '0;
    logic [PEND_W-1:0]  pend_bytes = '0;
    logic [LEN_W-1:0]   pend_len = LEN_NONE;
    logic [SEEN_W-1:0]  pend_seen = '0;

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    t_out_item   predicted;
    t_out_item   oldest;
    logic [7:0]  opening[0:24];

    utf8_stream_sanitizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void drop_partial();
        pend_point = '0;
        pend_bytes = '0;
        pend_len   = LEN_NONE;
        pend_seen  = '0;
    endfunction

    // shortest-form check: no overlong, no surrogate, nothing past the last plane
    function automatic bit scalar_ok(input logic [LEN_W-1:0] n, input logic [POINT_W-1:0] cp);
        case (n)
            LEN_TWO:   return cp >= MIN2 && cp <= MAX2;
            LEN_THREE: return (cp >= MIN3 && cp <= SURR_LO) || (cp >= SURR_HI && cp <= MAX3);
            LEN_FOUR:  return cp >= MIN4 && cp <= MAX4;
            default:   return 1'b0;
        endcase
    endfunction

    // advance the predicted decoder by one byte; returns 1 when a result is due
    function automatic bit decode_step(input t_in_item item, output t_out_item res);
        logic [7:0]         b;
        logic [POINT_W-1:0] pt;
        logic [RAW_W-1:0]   full;
        logic [LEN_W-1:0]   n;
        bit                 got;
        bit                 consumed;
        b        = item.text_byte;
        got      = 1'b0;
        consumed = 1'b0;
        res      = '0;
        // continuation of a pending sequence, or a break in it
        if (pend_len != LEN_NONE) begin
            if (b[7:6] == CONT_TAG) begin
                consumed = 1'b1;
                pt   = {pend_point[POINT_W-7:0], b[5:0]};
                full = RAW_W'(pend_bytes) | (RAW_W'(b) << (8 * pend_seen));
                if (({1'b0, pend_seen} + 3'd1) == pend_len) begin
                    n = pend_len;
                    drop_partial();
                    if (scalar_ok(n, pt)) begin
                        got                 = 1'b1;
                        res.code_point      = pt;
                        res.raw_sequence    = full;
                        res.sequence_length = n;
                    end
                end else begin
                    pend_point = pt;
                    pend_bytes = full[PEND_W-1:0];
                    pend_seen  = pend_seen + 2'd1;
                end
            end else begin
                drop_partial();
            end
        end
        // byte taken afresh
        if (!consumed && b != 8'h00) begin
            if (b[7] == 1'b0) begin
                got                 = 1'b1;
                res.code_point      = POINT_W'(b);
                res.raw_sequence    = RAW_W'(b);
                res.sequence_length = LEN_ONE;
            end else if (b[7:5] == 3'b110) begin
                pend_len   = LEN_TWO;
                pend_point = POINT_W'(b & MASK2);
            end else if (b[7:4] == 4'b1110) begin
                pend_len   = LEN_THREE;
                pend_point = POINT_W'(b & MASK3);
            end else if (b[7:3] == 5'b11110) begin
                pend_len   = LEN_FOUR;
                pend_point = POINT_W'(b & MASK4);
            end
            if (pend_len != LEN_NONE) begin
                pend_seen  = 2'd1;
                pend_bytes = PEND_W'(b);
            end
        end
        // last byte closes the text whatever is pending
        if (item.final_byte) begin
            drop_partial();
        end
        res.has_point   = got;
        res.end_of_text = item.final_byte;
        return got || item.final_byte;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        t_in_item item;
        item.text_byte  = b;
        item.final_byte = fin;
        text_queue.insert(text_queue.size(), item);
    endtask

    // utf-8 form of cp in n bytes, overlong or out of range if asked
    task automatic encode_point(input logic [POINT_W-1:0] cp, input int n,
                                ref logic [7:0] seq[$]);
        case (n)
            1: seq.insert(seq.size(), {1'b0, cp[6:0]});
            2: begin
                seq.insert(seq.size(), {3'b110, cp[10:6]});
                seq.insert(seq.size(), {CONT_TAG, cp[5:0]});
            end
            3: begin
                seq.insert(seq.size(), {4'b1110, cp[15:12]});
                seq.insert(seq.size(), {CONT_TAG, cp[11:6]});
                seq.insert(seq.size(), {CONT_TAG, cp[5:0]});
            end
            default: begin
                seq.insert(seq.size(), {5'b11110, cp[20:18]});
                seq.insert(seq.size(), {CONT_TAG, cp[17:12]});
                seq.insert(seq.size(), {CONT_TAG, cp[11:6]});
                seq.insert(seq.size(), {CONT_TAG, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [POINT_W-1:0] legal_point(input int n);
        case (n)
            1: return POINT_W'($urandom_range(1, 'h7F));
            2: return POINT_W'($urandom_range(MIN2, MAX2));
            3: begin
                if ($urandom_range(0, 1) == 0) begin
                    return POINT_W'($urandom_range(MIN3, SURR_LO));
                end
                return POINT_W'($urandom_range(SURR_HI, MAX3));
            end
            default: return POINT_W'($urandom_range(MIN4, MAX4));
        endcase
    endfunction

    // one random text: mostly well-formed points, some ill-formed, cut short or noise
    task automatic add_text();
        logic [7:0]         seq[$];
        logic [7:0]         part[$];
        logic [POINT_W-1:0] cp;
        int                 chunks;
        int                 kind;
        int                 n;
        int                 keep;
        chunks = $urandom_range(1, 10);
        repeat (chunks) begin
            kind = $urandom_range(0, 99);
            n    = $urandom_range(1, 4);
            if (kind < 60) begin
                encode_point(legal_point(n), n, seq);
            end else if (kind < 72) begin
                case ($urandom_range(0, 2))
                    0: begin
                        // overlong form
                        n  = $urandom_range(2, 4);
                        cp = (n == 2) ? POINT_W'($urandom_range(0, 'h7F)) :
                             (n == 3) ? POINT_W'($urandom_range(0, MAX2)) :
                                        POINT_W'($urandom_range(0, MAX3));
                        encode_point(cp, n, seq);
                    end
                    1: encode_point(POINT_W'($urandom_range('hD800, 'hDFFF)), 3, seq);
                    default: encode_point(POINT_W'($urandom_range('h110000, 'h1FFFFF)), 4, seq);
                endcase
            end else if (kind < 84) begin
                // sequence cut short
                n = $urandom_range(2, 4);
                part.delete();
                encode_point(legal_point(n), n, part);
                keep = $urandom_range(1, n - 1);
                for (int k = 0; k < keep; k++) begin
                    seq.insert(seq.size(), part[k]);
                end
            end else begin
                seq.insert(seq.size(), 8'($urandom_range(0, 255)));
            end
        end
        foreach (seq[k]) begin
            push_byte(seq[k], k == seq.size() - 1);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // sender: offers queued bytes with random gaps, holds a stalled transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item  <= '0;
            gap_left   = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (text_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (text_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else begin
                i_in_item  <= text_queue.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // receiver: stall bursts at random, none near the end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (text_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict on each accepted byte, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_step(i_in_item, predicted)) begin
                    points_due.insert(points_due.size(), predicted);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (points_due.size() == 0) begin
                    $display("%0t ns: result expected none actual %h", $time, o_out_item);
                    error_count++;
                end else begin
                    oldest = points_due.pop_front();
                    check_field("code_point", 32'(oldest.code_point),
                                32'(o_out_item.code_point));
                    check_field("raw_sequence", oldest.raw_sequence, o_out_item.raw_sequence);
                    check_field("sequence_length", 32'(oldest.sequence_length),
                                32'(o_out_item.sequence_length));
                    check_field("has_point", 32'(oldest.has_point),
                                32'(o_out_item.has_point));
                    check_field("end_of_text", 32'(oldest.end_of_text),
                                32'(o_out_item.end_of_text));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // extremes, lengths, overlong, surrogate, past the last plane, strays, break
        opening = '{8'h00, 8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC0, 8'h80,
                    8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                    8'hF4, 8'h90, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hE2, 8'h41, 8'hE2};
        foreach (opening[k]) begin
            push_byte(opening[k], 1'b0);
        end
        // last byte leaving a sequence open, then a last byte carrying a point
        push_byte(8'h82, 1'b1);
        push_byte(8'h5A, 1'b1);
        while (text_queue.size() < TEXT_TARGET) begin
            add_text();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (text_queue.size() != 0 || i_in_valid || points_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
